// ===== design/lre_pkg.sv =====
// shared constants and functions of the led ring effect generator
`default_nettype none
package lre_pkg;
  localparam int unsigned LED_COUNT = 8;
  localparam int unsigned SUB_STEPS = 256;

  localparam logic [2:0] CFG_EFFECT = 3'd0;
  localparam logic [2:0] CFG_RED    = 3'd1;
  localparam logic [2:0] CFG_GREEN  = 3'd2;
  localparam logic [2:0] CFG_BLUE   = 3'd3;
  localparam logic [2:0] CFG_BRIGHT = 3'd4;
  localparam logic [2:0] CFG_SPEED  = 3'd5;

  localparam logic [2:0] FX_OFF      = 3'd0;
  localparam logic [2:0] FX_STATIC   = 3'd1;
  localparam logic [2:0] FX_BREATH   = 3'd2;
  localparam logic [2:0] FX_RAINBOW  = 3'd3;
  localparam logic [2:0] FX_COMET    = 3'd4;
  localparam logic [2:0] FX_SWEEP    = 3'd5;
  localparam logic [2:0] FX_FOUNTAIN = 3'd6;
  localparam logic [2:0] FX_HICCUP   = 3'd7;

  // fountain fill level per step of the eight-step cycle
  function automatic logic [2:0] fill_level(input logic [2:0] idx);
    case (idx)
      3'd0: fill_level = 3'd0;
      3'd1: fill_level = 3'd1;
      3'd2: fill_level = 3'd2;
      3'd3: fill_level = 3'd3;
      3'd4: fill_level = 3'd4;
      3'd5: fill_level = 3'd3;
      3'd6: fill_level = 3'd2;
      default: fill_level = 3'd1;
    endcase
  endfunction

  // chain rank of an led: position within the right or left chain
  function automatic logic [1:0] chain_rank(input logic [2:0] led);
    case (led)
      3'd7, 3'd6: chain_rank = 2'd0;
      3'd0, 3'd5: chain_rank = 2'd1;
      3'd1, 3'd4: chain_rank = 2'd2;
      default:    chain_rank = 2'd3;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== design/lre_div.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module lre_div import lre_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [15:0] den_i,
  output logic             done_o,
  output logic [31:0]      quo_o,
  output logic [15:0]      rem_o
);
  logic [31:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [16:0] trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, quo_q[31]};
    if (start_i) begin
      quo_d = num_i; rem_d = '0; den_d = den_i; cnt_d = 6'd32; busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = 16'(trial - {1'b0, den_q});
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial[15:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

// ===== design/led_ring_effect_generator.sv =====
// top level of the led ring effect generator with its frame sequencer
// Usage: each input transfer (restart_i) renders one frame of eight ARGB
// words. The frame is delivered as one output transfer on led0..led7_argb_o.
// Configuration writes (cfg_index_i, cfg_data_i) are taken only while the
// sequencer is idle. A pending write holds off the input side for that cycle.
// Index 0 effect, 1 red, 2 green, 3 blue, 4 brightness, 5 speed.
// A sequencer runs around one shared 32-bit radix-2 divider. Breath and hiccup
// use up to two divisions, fountain one, and the other effects need none. Comet
// and sweep step through S_HW and S_WAIT for each led.
// The sequencer returns to idle as the frame is loaded into the output register,
// so in_ready_o can rise in the same cycle as out_valid_o.
// The finished frame moves to an output register. If that register is still
// full when the next frame is done, the sequencer waits and in_ready_o stays
// low until the receiver takes the older frame.
// Reset clears frame counter, head and colours, selects effect off, and sets brightness 10 and speed 5.
`default_nettype none
module led_ring_effect_generator import lre_pkg::*; #(
  parameter int unsigned SubSteps = SUB_STEPS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        restart_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      led0_argb_o,
  output logic [31:0]      led1_argb_o,
  output logic [31:0]      led2_argb_o,
  output logic [31:0]      led3_argb_o,
  output logic [31:0]      led4_argb_o,
  output logic [31:0]      led5_argb_o,
  output logic [31:0]      led6_argb_o,
  output logic [31:0]      led7_argb_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  localparam int unsigned SubW = $clog2(SubSteps);
  localparam int unsigned RingW = SubW + 3;
  localparam logic [RingW:0] RingLen = (RingW+1)'(LED_COUNT * SubSteps);
  localparam logic [RingW:0] TailLen = (RingW+1)'(3 * SubSteps);

  localparam logic [3:0] S_IDLE = 4'd0, S_AMAX = 4'd1, S_PH1 = 4'd2,
                         S_PH2 = 4'd3, S_PH3 = 4'd4, S_HW = 4'd5,
                         S_LED = 4'd6, S_FIN = 4'd7, S_WAIT = 4'd8;

  logic [2:0] effect_q; logic [7:0] red_q, green_q, blue_q;
  logic [3:0] bright_q, speed_q;
  logic [31:0] frame_q, frame_d, t_q, t_d;
  logic [RingW-1:0] head_q, head_d;
  logic [3:0] st_q, st_d;
  logic [2:0] led_q, led_d;
  logic [31:0] leds_q [LED_COUNT];
  logic [31:0] leds_d [LED_COUNT];
  logic [31:0] outs_q [LED_COUNT];
  logic [7:0] amax_q, amax_d;
  logic [31:0] tmp_q, tmp_d;
  logic [8:0]  hw_q, hw_d;
  logic out_valid_q, out_valid_d;
  logic out_load;

  logic        div_start, div_done;
  logic [31:0] div_num, div_quo;
  logic [15:0] div_den, div_rem;

  lre_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo), .rem_o(div_rem)
  );

  logic [3:0] spd, br;
  assign spd = (speed_q > 4'd10) ? 4'd10 : speed_q;
  assign br  = (bright_q > 4'd10) ? 4'd10 : bright_q;

  logic [6:0] period, half, decay, pause;
  always_comb begin
    period = 7'(7'd96 - 7'(7 * spd));
    if (period < 7'd24) period = 7'd24;
    half  = {1'b0, period[6:1]};
    decay = 7'(7'd16 - 7'(spd));
    pause = 7'(7'd4 + 7'((4'd10 - spd) >> 1));
  end

  function automatic logic [31:0] pack(input logic [7:0] a, input logic [7:0] r,
                                       input logic [7:0] g, input logic [7:0] b);
    pack = {a, r, g, b};
  endfunction

  function automatic logic [31:0] wheel(input logic [7:0] pos, input logic [7:0] a);
    logic [7:0] p;
    logic [9:0] p3;
    p = pos;
    if (pos < 8'd85) begin
      p3 = 10'(p) * 10'd3;
      wheel = pack(a, 8'(10'd255 - p3), p3[7:0], 8'd0);
    end else if (pos < 8'd170) begin
      p = pos - 8'd85;
      p3 = 10'(p) * 10'd3;
      wheel = pack(a, 8'd0, 8'(10'd255 - p3), p3[7:0]);
    end else begin
      p = pos - 8'd170;
      p3 = 10'(p) * 10'd3;
      wheel = pack(a, p3[7:0], 8'd0, 8'(10'd255 - p3));
    end
  endfunction

  // 255 - (255-c)*w/256 with w up to 256
  function automatic logic [7:0] twhite(input logic [7:0] c, input logic [8:0] w);
    logic [16:0] m;
    m = 17'(8'd255 - c) * 17'(w);
    twhite = 8'(9'd255 - 9'(m >> 8));
  endfunction

  // x/255 for x up to 255*255
  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [16:0] s;
    s = x + 17'd1 + (x >> 8);
    div255 = s[15:8];
  endfunction

  // distances of the current led to the head
  logic [RingW-1:0] center, dd, lag;
  logic [RingW:0] dmin;
  always_comb begin
    center = RingW'({led_q, SubW'(0)});
    dd  = RingW'(center - head_q);
    lag = RingW'(head_q - center);
    dmin = (RingW+1)'(dd);
    if (dmin > RingLen - dmin) dmin = RingLen - dmin;
  end

  // head and tail weights; the tail divides by three through 683/2048
  logic [16:0] hw_num;
  logic [17:0] tw_num;
  logic [9:0]  tw_x;
  logic [19:0] tw_prod;
  logic [8:0]  hw_c, tw_c, w_c;
  always_comb begin
    hw_num = '0;
    tw_num = '0;
    if (dmin < (RingW+1)'(SubSteps))
      hw_num = 17'((RingW+1)'(SubSteps) - dmin) << 8;
    if (effect_q == FX_COMET && (RingW+1)'(lag) < TailLen)
      tw_num = 18'(TailLen - (RingW+1)'(lag)) << 8;
    hw_c = 9'(hw_num >> SubW);
    tw_x = 10'(tw_num >> SubW);
    tw_prod = 20'(tw_x) * 20'd683;
    tw_c = 9'(tw_prod >> 11);
    w_c = (hw_q > tmp_q[8:0]) ? hw_q : tmp_q[8:0];
  end

  logic in_fire, out_fire;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;
  assign out_load = (st_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    st_d = st_q; led_d = led_q; frame_d = frame_q; t_d = t_q; head_d = head_q;
    amax_d = amax_q; tmp_d = tmp_q; hw_d = hw_q; out_valid_d = out_valid_q;
    leds_d = leds_q;
    div_start = 1'b0; div_num = '0; div_den = 16'd1;
    if (out_fire) out_valid_d = 1'b0;
    case (st_q)
      S_IDLE: if (in_fire) begin
        t_d = restart_i ? 32'd0 : frame_q;
        if (restart_i) head_d = '0;
        for (int k = 0; k < LED_COUNT; k++) leds_d[k] = '0;
        // br*255/10 equals br*51/2
        amax_d = 8'((9'(br) * 9'd51) >> 1);
        st_d = S_AMAX;
      end
      S_AMAX: begin
        led_d = '0;
        case (effect_q)
          FX_STATIC: begin
            for (int k = 0; k < LED_COUNT; k++)
              leds_d[k] = pack(amax_q, red_q, green_q, blue_q);
            st_d = S_FIN;
          end
          FX_RAINBOW: begin
            tmp_d = t_q * 32'(5'd1 + 5'(2 * spd));
            st_d = S_LED;
          end
          FX_BREATH: begin
            div_start = 1'b1; div_num = t_q; div_den = 16'(period); st_d = S_PH1;
          end
          FX_HICCUP: begin
            div_start = 1'b1; div_num = t_q; div_den = 16'(decay + pause);
            st_d = S_PH1;
          end
          FX_FOUNTAIN: begin
            div_start = 1'b1; div_num = t_q;
            div_den = 16'(6'd3 + 6'((4'd10 - spd) * 4)); st_d = S_PH1;
          end
          FX_COMET, FX_SWEEP: st_d = S_HW;
          default: st_d = S_FIN;
        endcase
      end
      S_PH1: if (div_done) begin
        case (effect_q)
          FX_BREATH: begin
            div_start = 1'b1;
            if (div_rem < 16'(half)) begin
              div_num = 32'(div_rem) * 32'd255; div_den = 16'(half);
            end else begin
              div_num = 32'(16'(period) - div_rem) * 32'd255;
              div_den = 16'(period - half);
            end
            st_d = S_PH2;
          end
          FX_HICCUP: begin
            if (div_rem < 16'(decay)) begin
              div_start = 1'b1;
              div_num = 32'(amax_q) * 32'(16'(decay) - div_rem);
              div_den = 16'(decay);
              st_d = S_PH3;
            end else begin
              tmp_d = '0; st_d = S_LED;
            end
          end
          default: begin
            for (int k = 0; k < LED_COUNT; k++)
              if (3'(chain_rank(3'(k))) < fill_level(div_quo[2:0]))
                leds_d[k] = pack(amax_q, red_q, green_q, blue_q);
            st_d = S_FIN;
          end
        endcase
      end
      S_PH2: if (div_done) begin
        tmp_d = 32'(div255(17'(amax_q) * 17'(div_quo[7:0])));
        st_d = S_LED;
      end
      S_PH3: if (div_done) begin
        tmp_d = div_quo; st_d = S_LED;
      end
      S_HW: begin
        hw_d = hw_c;
        tmp_d = 32'(tw_c);
        st_d = S_WAIT;
      end
      S_WAIT: begin
        // per-led weight ready: final step of comet or sweep
        if (effect_q == FX_COMET)
          leds_d[led_q] = pack(amax_q, twhite(red_q, w_c), twhite(green_q, w_c),
                               twhite(blue_q, w_c));
        else
          leds_d[led_q] = (w_c != 0) ?
            pack(8'((17'(amax_q) * 17'(w_c)) >> 8), red_q, green_q, blue_q) : '0;
        led_d = led_q + 3'd1;
        st_d = (led_q == 3'(LED_COUNT - 1)) ? S_FIN : S_HW;
      end
      S_LED: begin
        case (effect_q)
          FX_RAINBOW: begin
            for (int k = 0; k < LED_COUNT; k++)
              leds_d[k] = wheel(8'(tmp_q[7:0] + 8'(k * 32)), amax_q);
            st_d = S_FIN;
          end
          default: begin
            for (int k = 0; k < LED_COUNT; k++)
              leds_d[k] = pack(tmp_q[7:0], red_q, green_q, blue_q);
            st_d = S_FIN;
          end
        endcase
      end
      S_FIN: if (out_load) begin
        head_d = RingW'(head_q + RingW'(7'd6 + 7'(6 * spd)));
        frame_d = t_q + 32'd1;
        out_valid_d = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; led_q <= '0; frame_q <= '0; head_q <= '0;
      out_valid_q <= 1'b0;
      effect_q <= FX_OFF; red_q <= '0; green_q <= '0; blue_q <= '0;
      bright_q <= 4'd10; speed_q <= 4'd5;
    end else begin
      st_q <= st_d; led_q <= led_d; frame_q <= frame_d; head_q <= head_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_EFFECT: effect_q <= cfg_data_i[2:0];
          CFG_RED:    red_q    <= cfg_data_i[7:0];
          CFG_GREEN:  green_q  <= cfg_data_i[7:0];
          CFG_BLUE:   blue_q   <= cfg_data_i[7:0];
          CFG_BRIGHT: bright_q <= cfg_data_i[3:0];
          CFG_SPEED:  speed_q  <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end
  always_ff @(posedge clk_i) begin
    t_q <= t_d; amax_q <= amax_d; tmp_q <= tmp_d; hw_q <= hw_d; leds_q <= leds_d;
    if (out_load) outs_q <= leds_q;
  end

  assign cfg_ready_o = (st_q == S_IDLE);
  assign in_ready_o  = (st_q == S_IDLE) && !cfg_valid_i;
  assign out_valid_o = out_valid_q;
  assign led0_argb_o = outs_q[0];
  assign led1_argb_o = outs_q[1];
  assign led2_argb_o = outs_q[2];
  assign led3_argb_o = outs_q[3];
  assign led4_argb_o = outs_q[4];
  assign led5_argb_o = outs_q[5];
  assign led6_argb_o = outs_q[6];
  assign led7_argb_o = outs_q[7];
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// testbench for the led ring effect generator: frame prediction and checking
`timescale 1ns / 1ps
module tb;
  import lre_pkg::*;

  typedef logic [7:0][31:0] frame_t;

  // holds predicted frames in order and compares delivered ones against them
  class frame_scoreboard;
    frame_t expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function void note_frame(frame_t f);
      expected_q.push_back(f);
    endfunction

    function void check_frame(frame_t got);
      frame_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: frame with no prediction waiting, got %h", $realtime, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < 8; i++) begin
        if (want[i] !== got[i]) begin
          $display("%0t: led%0d_argb expected %h actual %h", $realtime, i, want[i], got[i]);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        restart_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] led0_argb_o, led1_argb_o, led2_argb_o, led3_argb_o;
  logic [31:0] led4_argb_o, led5_argb_o, led6_argb_o, led7_argb_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = CFG_EFFECT;
  logic [31:0] cfg_data_i = '0;

  led_ring_effect_generator dut (.*);

  frame_scoreboard frames = new();

  // predictor state
  logic [2:0]  fx_sel = FX_OFF;
  logic [7:0]  col_r = 8'd0, col_g = 8'd0, col_b = 8'd0;
  logic [3:0]  bright_step = 4'd10, speed_step = 4'd5;
  int unsigned frame_cnt = 0;
  logic [10:0] head_pos = '0;

  // sender and receiver idle percentages
  int unsigned send_idle_pct = 23;
  int unsigned recv_idle_pct = 75;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] argb(int unsigned a, int unsigned r, int unsigned g,
                                       int unsigned b);
    if (a > 255) a = 255;
    if (r > 255) r = 255;
    if (g > 255) g = 255;
    if (b > 255) b = 255;
    return {a[7:0], r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic logic [31:0] color_wheel(int unsigned pos, int unsigned a);
    pos = pos & 255;
    if (pos < 85) return argb(a, 255 - pos * 3, pos * 3, 0);
    if (pos < 170) begin
      pos = pos - 85;
      return argb(a, 0, 255 - pos * 3, pos * 3);
    end
    pos = pos - 170;
    return argb(a, pos * 3, 0, 255 - pos * 3);
  endfunction

  function automatic int unsigned blend_white(int unsigned c, int unsigned w);
    return 255 - ((255 - c) * w) / 256;
  endfunction

  // renders the next frame and advances counter and head
  function automatic frame_t render_frame(logic restart);
    frame_t f;
    int unsigned spd, br, amax, t, head;
    int unsigned period, phase, half, pulse, offset, tail, center, d, lag, hw, tw, w;
    int unsigned hold, level, decay, pause_len, a;
    int unsigned rank;
    f = '0;
    spd = (speed_step > 10) ? 10 : speed_step;
    br = (bright_step > 10) ? 10 : bright_step;
    amax = br * 255 / 10;
    if (restart) begin
      frame_cnt = 0;
      head_pos = '0;
    end
    t = frame_cnt;
    head = head_pos;
    case (fx_sel)
      FX_STATIC: begin
        for (int i = 0; i < 8; i++) f[i] = argb(amax, col_r, col_g, col_b);
      end
      FX_BREATH: begin
        period = 96 - 7 * spd;
        if (period < 24) period = 24;
        phase = t % period;
        half = period / 2;
        if (phase < half) pulse = phase * 255 / half;
        else pulse = (period - phase) * 255 / (period - half);
        for (int i = 0; i < 8; i++) f[i] = argb(amax * pulse / 255, col_r, col_g, col_b);
      end
      FX_RAINBOW: begin
        offset = (t * (1 + 2 * spd)) & 255;
        for (int i = 0; i < 8; i++) f[i] = color_wheel(offset + i * 32, amax);
      end
      FX_COMET, FX_SWEEP: begin
        tail = (fx_sel == FX_COMET) ? 768 : 0;
        for (int i = 0; i < 8; i++) begin
          center = i * 256;
          d = (center + 2048 - head) % 2048;
          lag = (head + 2048 - center) % 2048;
          hw = 0;
          tw = 0;
          if (d > 2048 - d) d = 2048 - d;
          if (d < 256) hw = 256 - d;
          if (tail > 0 && lag < tail) tw = 256 * (tail - lag) / tail;
          w = (hw > tw) ? hw : tw;
          if (fx_sel == FX_COMET)
            f[i] = argb(amax, blend_white(col_r, w), blend_white(col_g, w),
                        blend_white(col_b, w));
          else
            f[i] = (w > 0) ? argb(amax * w / 256, col_r, col_g, col_b) : 32'd0;
        end
      end
      FX_FOUNTAIN: begin
        hold = 3 + (10 - spd) * 4;
        case ((t / hold) & 7)
          0: level = 0;
          1, 7: level = 1;
          2, 6: level = 2;
          3, 5: level = 3;
          default: level = 4;
        endcase
        // leds 7,0,1,2 and 6,5,4,3 fill outward from the top
        for (int i = 0; i < 8; i++) begin
          case (i)
            7, 6: rank = 0;
            0, 5: rank = 1;
            1, 4: rank = 2;
            default: rank = 3;
          endcase
          if (rank < level) f[i] = argb(amax, col_r, col_g, col_b);
        end
      end
      FX_HICCUP: begin
        decay = 6 + (10 - spd);
        pause_len = 4 + (10 - spd) / 2;
        phase = t % (decay + pause_len);
        a = (phase < decay) ? amax * (decay - phase) / decay : 0;
        for (int i = 0; i < 8; i++) f[i] = argb(a, col_r, col_g, col_b);
      end
      default: ;
    endcase
    head_pos = 11'((head + 6 + 6 * spd) % 2048);
    frame_cnt = t + 1;
    return f;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == CFG_EFFECT) ? 32'h7 : (idx >= CFG_BRIGHT) ? 32'hf : 32'hff;
    // upper bits are don't-care, so randomize them
    value = (value & mask) | ($urandom() & ~mask);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    case (idx)
      CFG_EFFECT: fx_sel = value[2:0];
      CFG_RED:    col_r = value[7:0];
      CFG_GREEN:  col_g = value[7:0];
      CFG_BLUE:   col_b = value[7:0];
      CFG_BRIGHT: bright_step = value[3:0];
      CFG_SPEED:  speed_step = value[3:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup(logic [2:0] fx, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                       logic [3:0] br, logic [3:0] sp);
    write_reg(CFG_EFFECT, 32'(fx));
    write_reg(CFG_RED, 32'(r));
    write_reg(CFG_GREEN, 32'(g));
    write_reg(CFG_BLUE, 32'(b));
    write_reg(CFG_BRIGHT, 32'(br));
    write_reg(CFG_SPEED, 32'(sp));
  endtask

  task automatic send_frame(logic restart);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i <= restart;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    frames.note_frame(render_frame(restart));
  endtask

  // sender holds off until every predicted frame has been delivered
  task automatic drain();
    in_valid_i <= 1'b0;
    while (frames.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [3:0] pick_step();
    case ($urandom_range(0, 4))
      0: return 4'd0;
      1: return 4'd10;
      2: return 4'($urandom_range(11, 15));
      default: return 4'($urandom_range(0, 10));
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      frames.check_frame({led7_argb_o, led6_argb_o, led5_argb_o, led4_argb_o,
                          led3_argb_o, led2_argb_o, led1_argb_o, led0_argb_o});
  end

  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned n_items;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults, effect off
    send_frame(1'b0);
    send_frame(1'b1);
    drain();
    for (int fx = FX_STATIC; fx <= FX_HICCUP; fx++) begin
      case (fx % 3)
        0: setup(3'(fx), 8'hff, 8'h00, 8'hff, 4'd15, 4'd15);
        1: setup(3'(fx), 8'h00, 8'hff, 8'h00, 4'd0, 4'd0);
        default: setup(3'(fx), 8'h12, 8'h80, 8'hed, 4'd10, 4'd10);
      endcase
      send_frame(1'b0);
      send_frame(1'b1);
      send_frame(1'b0);
      drain();
    end

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 75;
        recv_idle_pct = 23;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      setup(3'($urandom_range(0, 7)), pick_byte(), pick_byte(), pick_byte(),
            pick_step(), pick_step());
      n_items = $urandom_range(45, 65);
      for (int k = 0; k < n_items; k++) send_frame($urandom_range(0, 99) < 4);
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (frames.errors == 0 && frames.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
